// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the biquad filter RTL.
// ----------------------------------------------------------------------------
// Define NO_ASSERTIONS to compile the design without its assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define PBQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define PBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PBQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/pbq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbq_pkg
// Types and constants shared by the biquad filter modules.
// ----------------------------------------------------------------------------
package pbq_pkg;

    // Coefficient registers are signed fixed point, always 32 bits.
    localparam int COEFF_BITS   = 32;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_B0 = 3'd0,
        CFG_B1 = 3'd1,
        CFG_B2 = 3'd2,
        CFG_A1 = 3'd3,
        CFG_A2 = 3'd4
    } t_cfg_idx;

    // Control that travels with an item from the feedforward pipe to the
    // feedback stage.
    typedef struct packed {
        logic valid;
        logic prime;
    } t_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/pbq_ff.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbq_ff
// Input history and three-stage feedforward pipe: samples, products, sum.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbq_ff #(
    parameter int SAMPLE_BITS     = 16,
    parameter int COEFF_FRAC_BITS = 30
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_valid,
    output logic                                      o_ready,
    input  wire signed [SAMPLE_BITS-1:0]              i_sample,
    input  wire signed [pbq_pkg::COEFF_BITS-1:0]      i_b0,
    input  wire signed [pbq_pkg::COEFF_BITS-1:0]      i_b1,
    input  wire signed [pbq_pkg::COEFF_BITS-1:0]      i_b2,
    input  wire                                       i_take,
    output pbq_pkg::t_ctl                             o_ctl,
    output logic signed [SAMPLE_BITS-1:0]             o_x,
    output logic signed [SAMPLE_BITS+33:0]            o_sum
);

    localparam int PW    = SAMPLE_BITS + pbq_pkg::COEFF_BITS;
    localparam int ACC_W = SAMPLE_BITS + 34;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (COEFF_FRAC_BITS - 1);

    logic                          r_primed;
    logic signed [SAMPLE_BITS-1:0] r_prev_in;
    logic signed [SAMPLE_BITS-1:0] r_prev_in_two;

    logic                          r_v1, r_v2, r_v3;
    logic                          r_p1, r_p2, r_p3;
    logic signed [SAMPLE_BITS-1:0] r_x1, r_x2, r_x3;
    logic signed [SAMPLE_BITS-1:0] r_h1, r_h2;
    logic signed [PW-1:0]          r_m0, r_m1, r_m2;
    logic signed [ACC_W-1:0]       r_sum;

    logic take1, take2, take3, acc_in, prime;

    assign take3   = !r_v3 || i_take;
    assign take2   = !r_v2 || take3;
    assign take1   = !r_v1 || take2;
    assign o_ready = take1;
    assign acc_in  = i_valid && take1;
    assign prime   = !r_primed;

    // Stage 1: capture the sample with the two inputs it is filtered against.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed      <= 1'b0;
            r_prev_in     <= '0;
            r_prev_in_two <= '0;
            r_v1          <= 1'b0;
        end else begin
            if (take1) begin
                r_v1 <= i_valid;
            end
            if (acc_in) begin
                r_primed      <= 1'b1;
                r_prev_in     <= i_sample;
                r_prev_in_two <= prime ? i_sample : r_prev_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_x1 <= i_sample;
            r_h1 <= r_prev_in;
            r_h2 <= r_prev_in_two;
            r_p1 <= prime;
        end
    end

    // Stage 2: three products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (take2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take2 && r_v1) begin
            r_m0 <= PW'(i_b0) * PW'(r_x1);
            r_m1 <= PW'(i_b1) * PW'(r_h1);
            r_m2 <= PW'(i_b2) * PW'(r_h2);
            r_x2 <= r_x1;
            r_p2 <= r_p1;
        end
    end

    // Stage 3: feedforward sum with the rounding half folded in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (take3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take3 && r_v2) begin
            r_sum <= ACC_W'(r_m0) + ACC_W'(r_m1) + ACC_W'(r_m2) + RND;
            r_x3  <= r_x2;
            r_p3  <= r_p2;
        end
    end

    assign o_ctl.valid = r_v3;
    assign o_ctl.prime = r_p3;
    assign o_x         = r_x3;
    assign o_sum       = r_sum;

    `PBQ_ASSERT_IMPL(a_item_after_prime, i_clk, i_rst_n, r_v1, r_primed, "item in pipe before priming")
    `PBQ_ASSERT_NEXT(a_stage3_holds, i_clk, i_rst_n, r_v3 && !i_take, r_v3 && $stable(r_sum), "stalled sum changed")

endmodule

`default_nettype wire

// ----- hw/rtl/pbq_fb.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbq_fb
// Feedback stage: adds the output history terms, rounds, saturates and
// holds the result for the output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbq_fb #(
    parameter int SAMPLE_BITS     = 16,
    parameter int COEFF_FRAC_BITS = 30
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire pbq_pkg::t_ctl                        i_ctl,
    input  wire signed [SAMPLE_BITS-1:0]              i_x,
    input  wire signed [SAMPLE_BITS+33:0]             i_sum,
    input  wire signed [pbq_pkg::COEFF_BITS-1:0]      i_a1,
    input  wire signed [pbq_pkg::COEFF_BITS-1:0]      i_a2,
    output logic                                      o_take,
    input  wire                                       i_stall,
    output logic                                      o_valid,
    output logic signed [SAMPLE_BITS-1:0]             o_sample
);

    localparam int PW    = SAMPLE_BITS + pbq_pkg::COEFF_BITS;
    localparam int ACC_W = SAMPLE_BITS + 34;
    localparam int QW    = ACC_W - COEFF_FRAC_BITS;
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;
    logic signed [SAMPLE_BITS-1:0] r_y1;
    logic signed [SAMPLE_BITS-1:0] r_y2;

    logic signed [PW-1:0]          n_f1, n_f2;
    logic signed [ACC_W-1:0]       n_acc;
    logic signed [QW-1:0]          n_q;
    logic [QW-SAMPLE_BITS:0]       n_top;
    logic signed [SAMPLE_BITS-1:0] n_y;
    logic                          fire;

    assign o_take = !r_out_valid || !i_stall;
    assign fire   = i_ctl.valid && o_take;

    always_comb begin
        n_f1  = PW'(i_a1) * PW'(r_y1);
        n_f2  = PW'(i_a2) * PW'(r_y2);
        n_acc = i_sum + ACC_W'(n_f1) + ACC_W'(n_f2);
        n_q   = n_acc[ACC_W-1:COEFF_FRAC_BITS];
        // The result fits when every bit above the sample's sign bit matches it.
        n_top = n_q[QW-1:SAMPLE_BITS-1];
        if (i_ctl.prime) begin
            n_y = i_x;
        end else if ((&n_top) || !(|n_top)) begin
            n_y = n_q[SAMPLE_BITS-1:0];
        end else if (n_q[QW-1]) begin
            n_y = S_MIN;
        end else begin
            n_y = S_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_y1        <= '0;
            r_y2        <= '0;
        end else begin
            if (o_take) begin
                r_out_valid <= i_ctl.valid;
            end
            if (fire) begin
                r_y1 <= n_y;
                r_y2 <= i_ctl.prime ? i_x : r_y1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_y;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sample = r_out;

    `PBQ_ASSERT_NEXT(a_prime_passes, i_clk, i_rst_n, fire && i_ctl.prime,
                     (r_out == $past(i_x)) && (r_y2 == r_out),
                     "priming item not passed through")

endmodule

`default_nettype wire

// ----- hw/rtl/primed_biquad_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// primed_biquad_filter
// Single-section direct form I biquad IIR filter with priming on first item.
// ----------------------------------------------------------------------------
// Each accepted sample gives one output y = b0*x + b1*x1 + b2*x2 + a1*y1 +
// a2*y2, where a1 and a2 are loaded already negated. Coefficients are signed
// 32-bit fixed point with COEFF_FRAC_BITS fraction bits and are written
// through the plain write port (index 0..4 = b0, b1, b2, a1, a2; other indexes
// are ignored), by the user only while the filter is idle; the block does not
// enforce this. Products are summed exactly, rounded to nearest with ties
// toward plus infinity and saturated to SAMPLE_BITS. The first item after
// reset loads all four history registers with itself and comes out unchanged.
// The filter takes one item per clock cycle while the input is not stalled.
// The clock is bounded by the last stage, where the two feedback products, the
// three-way add and the saturation close the loop through the previous-output
// register. A stall on the output backs up through the pipe, so the input
// stalls only when all four stages hold items.

`include "assert_macros.svh"

module primed_biquad_filter #(
    parameter int SAMPLE_BITS     = 16,
    parameter int COEFF_FRAC_BITS = 30
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // Configuration write port.
    input  wire                                   i_cfg_we,
    input  wire [pbq_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  wire [pbq_pkg::COEFF_BITS-1:0]         i_cfg_data,
    // Input sample channel.
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  wire signed [SAMPLE_BITS-1:0]          i_sample_in,
    // Output sample channel.
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output logic signed [SAMPLE_BITS-1:0]         o_sample_out
);

    logic signed [pbq_pkg::COEFF_BITS-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;

    pbq_pkg::t_ctl                ff_ctl;
    logic signed [SAMPLE_BITS-1:0]  ff_x;
    logic signed [SAMPLE_BITS+33:0] ff_sum;
    logic                           ff_ready;
    logic                           fb_take;

    // Coefficient registers; writes never touch the filter history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= '0;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pbq_pkg::CFG_B0: r_b0 <= i_cfg_data;
                pbq_pkg::CFG_B1: r_b1 <= i_cfg_data;
                pbq_pkg::CFG_B2: r_b2 <= i_cfg_data;
                pbq_pkg::CFG_A1: r_a1 <= i_cfg_data;
                pbq_pkg::CFG_A2: r_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pbq_ff #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_ff (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (ff_ready),
        .i_sample (i_sample_in),
        .i_b0     (r_b0),
        .i_b1     (r_b1),
        .i_b2     (r_b2),
        .i_take   (fb_take),
        .o_ctl    (ff_ctl),
        .o_x      (ff_x),
        .o_sum    (ff_sum)
    );

    pbq_fb #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_fb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ff_ctl),
        .i_x      (ff_x),
        .i_sum    (ff_sum),
        .i_a1     (r_a1),
        .i_a2     (r_a2),
        .o_take   (fb_take),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_sample (o_sample_out)
    );

    assign o_stall = !ff_ready;

    `PBQ_ASSERT_IMPL(a_stall_only_when_full, i_clk, i_rst_n, o_stall,
                     o_valid && i_stall && ff_ctl.valid,
                     "input stalled with room in the pipe")

endmodule

`default_nettype wire
